// ----- design/oaht_pkg.sv -----
// Shared types, constants and command/status structs for the open addressing hash table.
// Used by every module of the block but oaht_ram; depends on nothing.
package oaht_pkg;

	localparam int MIN_CAP = 8;
	localparam int MAX_CAP = 1024;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int HASH_W  = 32;
	localparam int IDX_W   = $clog2(MAX_CAP);
	localparam int ADDR_W  = IDX_W + 1;
	localparam int CAP_W   = IDX_W + 1;
	localparam int MIN_LOG = $clog2(MIN_CAP);
	localparam int MAX_LOG = IDX_W;
	localparam int LOG_TOP = IDX_W + 2;
	localparam int LOG_W   = $clog2(LOG_TOP + 1);
	localparam int KVH_W   = KEY_W + VAL_W + HASH_W;
	localparam int SLOTS   = 2 * MAX_CAP;
	localparam int IN_W    = 112;
	localparam int OUT_W   = 88;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_SEARCH = 3'd1,
		OP_REMOVE = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		RS_INSERTED  = 3'd0,
		RS_REPLACED  = 3'd1,
		RS_FOUND     = 3'd2,
		RS_NOT_FOUND = 3'd3,
		RS_FULL      = 3'd4,
		RS_DONE      = 3'd5
	} res_status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_DEAD  = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		RV_ZERO,
		RV_FIN,
		RV_RD
	} val_sel_t;

	typedef enum logic [1:0] {
		RK_ITEM,
		RK_ZERO,
		RK_RD
	} key_sel_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_DISP,
		S_PRD,
		S_PEV,
		S_INS,
		S_SRCH,
		S_RH_START,
		S_RH_CLR,
		S_RH_RD,
		S_RH_EV,
		S_RH_WR,
		S_RH_DONE,
		S_SLOT_EV,
		S_FIN
	} state_t;

	typedef struct packed {
		logic        ld_item;
		logic        clear_state;
		logic        clr_wr;
		logic        prb_init;
		logic        prb_rh;
		logic        prb_rd;
		logic        prb_ev;
		logic        ins_new;
		logic        ins_rep;
		logic        rem_mark;
		logic        rh_start;
		logic        rh_rd;
		logic        rh_latch;
		logic        rh_wr;
		logic        rh_next;
		logic        rh_commit;
		logic        slot_rd;
		logic        res_we;
		res_status_t res_status;
		val_sel_t    res_val_sel;
		key_sel_t    res_key_sel;
		logic        res_live;
		logic        fin;
	} cmd_t;

	typedef struct packed {
		op_t   op;
		logic  clr_last;
		logic  p_done;
		mark_t fin_mark;
		mark_t rd_mark;
		logic  ins_room;
		logic  rh_fail;
		logic  rh_last;
		logic  slot_in_range;
		logic  out_free;
	} sts_t;

endpackage

// ----- design/open_addressing_hash_table_top.sv -----
// Open addressing hash table, top level: controller plus datapath on stream ports.
// Depends on oaht_pkg, oaht_ctrl, oaht_datapath.
//
// One operation at a time. Each probe step is a read, then an evaluate, on the single-port slot
// memory, for search, remove and insert alike. Clear runs a clearing pass over the eight
// slots of bank 0, and an insert that grows the table adds a rehash that clears the new bank
// and reprobes every live entry into it. After reset a clearing pass over the eight slots of
// bank 0 runs before the first beat is accepted. The result register lets a finished beat
// wait on the output while the next operation is taken in.
module open_addressing_hash_table_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,  // op
	input  logic [111:0] s_tdata,  // key, hash, value, slot_index
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [2:0]   m_tuser,  // status
	output logic [87:0]  m_tdata   // result_value, result_key, slot_live, entry_count,
	                               // table_capacity
);
	import oaht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	oaht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	oaht_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
	);
endmodule

// ----- design/oaht_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module oaht_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic [$clog2(D)-1:0] addr,
	input  logic                 we,
	input  logic [W-1:0]         wdata,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end
endmodule

// ----- design/oaht_datapath.sv -----
// Datapath: slot memories, probe unit, table counters, result and output registers.
// Depends on oaht_pkg and oaht_ram; driven by oaht_ctrl commands.
module oaht_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oaht_pkg::cmd_t       cmd,
	output oaht_pkg::sts_t       sts,
	input  logic [2:0]           s_tuser,
	input  logic [oaht_pkg::IN_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2:0]           m_tuser,
	output logic [oaht_pkg::OUT_W-1:0] m_tdata
);
	import oaht_pkg::*;

	logic              bank_q;
	logic [LOG_W-1:0]  caplog_q, nl_q, nl_c;
	logic [CAP_W-1:0]  live_q, occ_q, cap_c, newcap_c;
	op_t               op_q;
	logic [KEY_W-1:0]  key_q;
	logic [HASH_W-1:0] hash_q;
	logic [VAL_W-1:0]  val_q;
	logic [IDX_W-1:0]  sidx_q;

	logic              clr_bank_q;
	logic [IDX_W-1:0]  clr_cnt_q, clr_last_q;
	logic [IDX_W-1:0]  rh_i_q;
	logic [KEY_W-1:0]  rh_key_q;
	logic [VAL_W-1:0]  rh_val_q;
	logic [HASH_W-1:0] rh_hash_q;

	logic              p_bank_q, p_cmp_q, p_free_v_q;
	logic [IDX_W-1:0]  p_mask_q, p_idx_q, p_free_q, fin_idx_q;
	logic [CAP_W-1:0]  p_lim_q, p_step_q;
	logic [HASH_W-1:0] p_h_q;
	logic [KEY_W-1:0]  p_key_q;
	mark_t             fin_mark_q;
	logic [VAL_W-1:0]  fin_val_q;

	res_status_t       res_status_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [KEY_W-1:0]  res_key_q;
	logic              res_live_q;
	logic              out_valid_q;
	logic [2:0]        out_user_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [ADDR_W-1:0] addr_c;
	logic              mk_we, kv_we;
	logic [1:0]        mk_wdata, mk_rdata;
	logic [KVH_W-1:0]  kv_wdata, kv_rdata;
	logic [KEY_W-1:0]  rd_key;
	logic [VAL_W-1:0]  rd_val;
	logic [HASH_W-1:0] rd_hash;
	mark_t             rd_mark;

	logic              hit_empty, hit_match, lim_hit, free_v_n;
	logic [IDX_W-1:0]  nidx, free_n;
	logic [CAP_W-1:0]  nstep;
	logic [CAP_W+2:0]  mu_c;

	assign rd_key  = kv_rdata[KEY_W-1:0];
	assign rd_val  = kv_rdata[KEY_W+VAL_W-1:KEY_W];
	assign rd_hash = kv_rdata[KVH_W-1:KEY_W+VAL_W];
	assign rd_mark = mark_t'(mk_rdata);
	assign cap_c    = CAP_W'(1) << caplog_q;
	assign newcap_c = CAP_W'(1) << nl_q;

	always_comb begin
		mu_c = {2'b00, occ_q, 1'b0};
		nl_c = LOG_W'(LOG_TOP);
		for (int l = LOG_TOP; l >= MIN_LOG; l--) begin
			if (((CAP_W+3)'(1) << l) > mu_c) nl_c = LOG_W'(l);
		end
	end

	always_comb begin
		hit_empty = (rd_mark == MARK_EMPTY);
		hit_match = (rd_mark == MARK_LIVE) && p_cmp_q && (rd_key == p_key_q);
		nidx      = ((p_idx_q << 2) + p_idx_q + IDX_W'(1) + p_h_q[IDX_W-1:0]) & p_mask_q;
		nstep     = p_step_q + CAP_W'(1);
		lim_hit   = (nstep == p_lim_q);
		free_v_n  = p_free_v_q || (rd_mark == MARK_DEAD);
		free_n    = p_free_v_q ? p_free_q : p_idx_q;
	end

	always_comb begin
		addr_c   = {bank_q, fin_idx_q};
		mk_we    = 1'b0;
		kv_we    = 1'b0;
		mk_wdata = MARK_EMPTY;
		kv_wdata = {hash_q, val_q, key_q};
		if (cmd.clr_wr) begin
			addr_c = {clr_bank_q, clr_cnt_q};
			mk_we  = 1'b1;
		end else if (cmd.prb_rd) begin
			addr_c = {p_bank_q, p_idx_q};
		end else if (cmd.slot_rd) begin
			addr_c = {bank_q, sidx_q};
		end else if (cmd.rh_rd) begin
			addr_c = {bank_q, rh_i_q};
		end else if (cmd.ins_new) begin
			mk_we    = 1'b1;
			kv_we    = 1'b1;
			mk_wdata = MARK_LIVE;
		end else if (cmd.ins_rep) begin
			kv_we = 1'b1;
		end else if (cmd.rem_mark) begin
			mk_we    = 1'b1;
			mk_wdata = MARK_DEAD;
		end else if (cmd.rh_wr) begin
			addr_c   = {p_bank_q, fin_idx_q};
			mk_we    = 1'b1;
			kv_we    = 1'b1;
			mk_wdata = MARK_LIVE;
			kv_wdata = {rh_hash_q, rh_val_q, rh_key_q};
		end
	end

	oaht_ram #(.W(2), .D(SLOTS)) u_marks (
		.clk(clk), .addr(addr_c), .we(mk_we), .wdata(mk_wdata), .rdata(mk_rdata)
	);

	oaht_ram #(.W(KVH_W), .D(SLOTS)) u_slots (
		.clk(clk), .addr(addr_c), .we(kv_we), .wdata(kv_wdata), .rdata(kv_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			op_q   <= op_t'(s_tuser);
			key_q  <= s_tdata[KEY_W-1:0];
			hash_q <= s_tdata[KEY_W+HASH_W-1:KEY_W];
			val_q  <= s_tdata[KEY_W+HASH_W+VAL_W-1:KEY_W+HASH_W];
			sidx_q <= s_tdata[KEY_W+HASH_W+VAL_W+IDX_W-1:KEY_W+HASH_W+VAL_W];
		end
		if (cmd.rh_latch) begin
			rh_key_q  <= rd_key;
			rh_val_q  <= rd_val;
			rh_hash_q <= rd_hash;
		end
		if (cmd.rh_start) nl_q <= nl_c;
		if (cmd.prb_init) begin
			p_bank_q   <= cmd.prb_rh ? ~bank_q : bank_q;
			p_mask_q   <= cmd.prb_rh ? IDX_W'(newcap_c - CAP_W'(1)) : IDX_W'(cap_c - CAP_W'(1));
			p_lim_q    <= (cmd.prb_rh ? newcap_c : cap_c) + CAP_W'(8);
			p_key_q    <= cmd.prb_rh ? rd_key : key_q;
			p_h_q      <= cmd.prb_rh ? rd_hash : hash_q;
			p_idx_q    <= (cmd.prb_rh ? rd_hash[IDX_W-1:0] : hash_q[IDX_W-1:0])
			              & (cmd.prb_rh ? IDX_W'(newcap_c - CAP_W'(1))
			                            : IDX_W'(cap_c - CAP_W'(1)));
			p_step_q   <= '0;
			p_free_v_q <= 1'b0;
			p_cmp_q    <= !cmd.prb_rh;
		end else if (cmd.prb_ev) begin
			if (hit_match) begin
				fin_idx_q  <= p_idx_q;
				fin_mark_q <= MARK_LIVE;
				fin_val_q  <= rd_val;
			end else if (hit_empty) begin
				fin_idx_q  <= p_free_v_q ? p_free_q : p_idx_q;
				fin_mark_q <= p_free_v_q ? MARK_DEAD : MARK_EMPTY;
			end else if (lim_hit) begin
				fin_idx_q  <= free_v_n ? free_n : nidx;
				fin_mark_q <= free_v_n ? MARK_DEAD : MARK_EMPTY;
			end else begin
				p_idx_q    <= nidx;
				p_h_q      <= p_h_q >> 5;
				p_step_q   <= nstep;
				p_free_q   <= free_n;
				p_free_v_q <= free_v_n;
			end
		end
		if (cmd.res_we) begin
			res_status_q <= cmd.res_status;
			res_live_q   <= cmd.res_live;
			case (cmd.res_val_sel)
				RV_FIN:  res_val_q <= fin_val_q;
				RV_RD:   res_val_q <= rd_val;
				default: res_val_q <= '0;
			endcase
			case (cmd.res_key_sel)
				RK_RD:   res_key_q <= rd_key;
				RK_ZERO: res_key_q <= '0;
				default: res_key_q <= key_q;
			endcase
		end
		if (cmd.fin) begin
			out_user_q <= res_status_q;
			out_data_q <= {1'b0, cap_c, live_q, res_live_q, res_key_q, res_val_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			caplog_q    <= LOG_W'(MIN_LOG);
			live_q      <= '0;
			occ_q       <= '0;
			clr_bank_q  <= 1'b0;
			clr_cnt_q   <= '0;
			clr_last_q  <= IDX_W'(MIN_CAP - 1);
			rh_i_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_state) begin
				bank_q     <= 1'b0;
				caplog_q   <= LOG_W'(MIN_LOG);
				live_q     <= '0;
				occ_q      <= '0;
				clr_bank_q <= 1'b0;
				clr_cnt_q  <= '0;
				clr_last_q <= IDX_W'(MIN_CAP - 1);
			end
			if (cmd.rh_start) begin
				clr_bank_q <= ~bank_q;
				clr_cnt_q  <= '0;
				clr_last_q <= IDX_W'((CAP_W'(1) << nl_c) - CAP_W'(1));
				rh_i_q     <= '0;
			end
			if (cmd.clr_wr) clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			if (cmd.rh_next) rh_i_q <= rh_i_q + IDX_W'(1);
			if (cmd.ins_new) begin
				live_q <= live_q + CAP_W'(1);
				if (fin_mark_q == MARK_EMPTY) occ_q <= occ_q + CAP_W'(1);
			end
			if (cmd.rem_mark) live_q <= live_q - CAP_W'(1);
			if (cmd.rh_commit) begin
				bank_q   <= ~bank_q;
				caplog_q <= nl_q;
				occ_q    <= live_q;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.op            = op_q;
		sts.clr_last      = (clr_cnt_q == clr_last_q);
		sts.p_done        = hit_empty || hit_match || lim_hit;
		sts.fin_mark      = fin_mark_q;
		sts.rd_mark       = rd_mark;
		sts.ins_room      = ({2'b00, occ_q} + 13'd1) * 13'd3 < {1'b0, cap_c, 1'b0};
		sts.rh_fail       = (nl_c > LOG_W'(MAX_LOG));
		sts.rh_last       = (rh_i_q == IDX_W'(cap_c - CAP_W'(1)));
		sts.slot_in_range = ({1'b0, sidx_q} < cap_c);
		sts.out_free      = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = out_data_q;

	a_live_le_occ: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= occ_q) else $error("live count above occupied count");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		{2'b00, occ_q} * 13'd3 < {1'b0, cap_c, 1'b0}) else $error("load factor exceeded");
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (!out_valid_q || m_tready)) else $error("result overwritten");
endmodule

// ----- design/oaht_ctrl.sv -----
// Controller state machine: sequences probe, insert, remove, clear, read and rehash.
// Depends on oaht_pkg; drives oaht_datapath through cmd_t and reads sts_t.
module oaht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  oaht_pkg::sts_t sts,
	output oaht_pkg::cmd_t cmd
);
	import oaht_pkg::*;

	state_t     state_q, state_n;
	logic       clr_op_q, rh_mode_q;
	logic [1:0] tries_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_op_q  <= 1'b0;
			rh_mode_q <= 1'b0;
			tries_q   <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.ld_item) tries_q <= '0;
			if (cmd.rh_commit) tries_q <= tries_q + 2'd1;
			if (cmd.clear_state) clr_op_q <= 1'b1;
			else if (state_q == S_CLR && sts.clr_last) clr_op_q <= 1'b0;
			if (cmd.rh_start) rh_mode_q <= 1'b1;
			else if (cmd.rh_commit) rh_mode_q <= 1'b0;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_CLR:      if (sts.clr_last) state_n = clr_op_q ? S_FIN : S_IDLE;
			S_IDLE:     if (s_tvalid) state_n = S_DISP;
			S_DISP: begin
				unique case (sts.op) inside
					OP_INSERT, OP_SEARCH, OP_REMOVE: state_n = S_PRD;
					OP_CLEAR: state_n = S_CLR;
					OP_READ:  state_n = sts.slot_in_range ? S_SLOT_EV : S_FIN;
					default:  state_n = S_FIN;
				endcase
			end
			S_PRD:      state_n = S_PEV;
			S_PEV: begin
				if (sts.p_done) begin
					if (rh_mode_q) state_n = S_RH_WR;
					else if (sts.op == OP_INSERT) state_n = S_INS;
					else state_n = S_SRCH;
				end else begin
					state_n = S_PRD;
				end
			end
			S_INS: begin
				if (sts.fin_mark == MARK_LIVE || sts.ins_room) state_n = S_FIN;
				else state_n = S_RH_START;
			end
			S_SRCH:     state_n = S_FIN;
			S_RH_START: state_n = sts.rh_fail ? S_FIN : S_RH_CLR;
			S_RH_CLR:   if (sts.clr_last) state_n = S_RH_RD;
			S_RH_RD:    state_n = S_RH_EV;
			S_RH_EV: begin
				if (sts.rd_mark == MARK_LIVE) state_n = S_PRD;
				else state_n = sts.rh_last ? S_RH_DONE : S_RH_RD;
			end
			S_RH_WR:    state_n = sts.rh_last ? S_RH_DONE : S_RH_RD;
			S_RH_DONE:  state_n = (tries_q == 2'd3) ? S_FIN : S_DISP;
			S_SLOT_EV:  state_n = S_FIN;
			S_FIN:      if (sts.out_free) state_n = S_IDLE;
			default:    state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.res_status  = RS_DONE;
		cmd.res_val_sel = RV_ZERO;
		cmd.res_key_sel = RK_ITEM;
		s_tready        = 1'b0;
		unique case (state_q)
			S_CLR: cmd.clr_wr = 1'b1;
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.ld_item = s_tvalid;
			end
			S_DISP: begin
				unique case (sts.op) inside
					OP_INSERT, OP_SEARCH, OP_REMOVE: cmd.prb_init = 1'b1;
					OP_CLEAR: begin
						cmd.clear_state = 1'b1;
						cmd.res_we      = 1'b1;
					end
					OP_READ: begin
						if (sts.slot_in_range) begin
							cmd.slot_rd = 1'b1;
						end else begin
							cmd.res_we      = 1'b1;
							cmd.res_status  = RS_NOT_FOUND;
							cmd.res_key_sel = RK_ZERO;
						end
					end
					default: cmd.res_we = 1'b1;
				endcase
			end
			S_PRD: cmd.prb_rd = 1'b1;
			S_PEV: cmd.prb_ev = 1'b1;
			S_INS: begin
				cmd.res_we = 1'b1;
				if (sts.fin_mark == MARK_LIVE) begin
					cmd.ins_rep     = 1'b1;
					cmd.res_status  = RS_REPLACED;
					cmd.res_val_sel = RV_FIN;
				end else if (sts.ins_room) begin
					cmd.ins_new    = 1'b1;
					cmd.res_status = RS_INSERTED;
				end else begin
					cmd.res_we = 1'b0;
				end
			end
			S_SRCH: begin
				cmd.res_we = 1'b1;
				if (sts.fin_mark == MARK_LIVE) begin
					cmd.res_status  = RS_FOUND;
					cmd.res_val_sel = RV_FIN;
					cmd.rem_mark    = (sts.op == OP_REMOVE);
				end else begin
					cmd.res_status = RS_NOT_FOUND;
				end
			end
			S_RH_START: begin
				if (sts.rh_fail) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = RS_FULL;
				end else begin
					cmd.rh_start = 1'b1;
				end
			end
			S_RH_CLR: cmd.clr_wr = 1'b1;
			S_RH_RD:  cmd.rh_rd = 1'b1;
			S_RH_EV: begin
				if (sts.rd_mark == MARK_LIVE) begin
					cmd.prb_init = 1'b1;
					cmd.prb_rh   = 1'b1;
					cmd.rh_latch = 1'b1;
				end else begin
					cmd.rh_next = !sts.rh_last;
				end
			end
			S_RH_WR: begin
				cmd.rh_wr   = 1'b1;
				cmd.rh_next = !sts.rh_last;
			end
			S_RH_DONE: begin
				cmd.rh_commit  = 1'b1;
				cmd.res_we     = (tries_q == 2'd3);
				cmd.res_status = RS_FULL;
			end
			S_SLOT_EV: begin
				cmd.res_we = 1'b1;
				if (sts.rd_mark == MARK_LIVE) begin
					cmd.res_status  = RS_FOUND;
					cmd.res_val_sel = RV_RD;
					cmd.res_key_sel = RK_RD;
					cmd.res_live    = 1'b1;
				end else begin
					cmd.res_status  = RS_NOT_FOUND;
					cmd.res_key_sel = RK_ZERO;
				end
			end
			S_FIN: cmd.fin = sts.out_free;
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rh_mode_q) else $error("input taken during rehash");
	a_rh_wr_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rh_wr |-> rh_mode_q) else $error("rehash write outside rehash");
	a_commit_prev: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rh_commit |-> $past(state_q == S_RH_EV || state_q == S_RH_WR))
		else $error("rehash commit without walk");
endmodule
